/* rtl/lsbt_pkg.sv */
// shared types and constants for the lru segment buffer tracker
// no dependencies; imported by lsbt_cell and lru_segment_buffer_tracker
`timescale 1ns / 1ps
`default_nettype none
package lsbt_pkg;

  // default number of key cells in the chain
  localparam int ENTRIES_DEF = 16;

  // key field widths, fixed by the word fields
  localparam int FILE_ID_BITS = 16;
  localparam int SEG_ID_BITS  = 24;

  // configuration register map
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;
  localparam int CAP_BITS      = 5;
  localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
  localparam logic [CFG_ADDR_BITS-1:0] ADDR_CAPACITY = 3'd0;

  // command codes
  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  // status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2
  } status_t;

  // one stored key
  typedef struct packed {
    logic [FILE_ID_BITS-1:0] file_id;
    logic [SEG_ID_BITS-1:0]  seg_id;
  } key_t;

  // input word
  typedef struct packed {
    logic [1:0]              cmd;
    logic [FILE_ID_BITS-1:0] file_id;
    logic [SEG_ID_BITS-1:0]  seg_id;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [1:0]              status;
    logic                    present;
    logic                    evicted;
    logic [FILE_ID_BITS-1:0] evicted_file_id;
    logic [SEG_ID_BITS-1:0]  evicted_seg_id;
    logic                    added;
  } out_word_t;

  // per-cell update control
  typedef struct packed {
    logic shift;  // take the younger neighbor's key
    logic load;   // take the incoming key
  } cell_ctl_t;

endpackage
`default_nettype wire

/* rtl/lsbt_cell.sv */
// one key cell of the recency chain: holds a key, compares it, shifts or loads
// depends on lsbt_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsbt_cell
  import lsbt_pkg::*;
(
  input  wire logic      clk,
  input  wire key_t      nbr_key,   // key of the next younger cell
  input  wire key_t      in_key,    // key of the current word
  input  wire cell_ctl_t ctl,
  output key_t           key,
  output logic           hit
);

  key_t key_r;
  key_t key_nxt;

  // load beats shift; otherwise hold
  always_comb begin
    key_nxt = key_r;
    if (ctl.load) begin
      key_nxt = in_key;
    end else if (ctl.shift) begin
      key_nxt = nbr_key;
    end
  end

  // key storage, no reset
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key = key_r;
  assign hit = (key_r == in_key);

endmodule
`default_nettype wire

/* rtl/lru_segment_buffer_tracker.sv */
// lru segment buffer tracker: chain of key cells, oldest at cell 0
// depends on lsbt_pkg and lsbt_cell
`timescale 1ns / 1ps
// result: out_valid strobes in the cycle after start is taken
// throughput: one word per cycle, busy stays low; all cells compare in parallel
//   and shift or load by one place in the same cycle
// reset: held count cleared, capacity set to 16, no result pending;
//   key cells are not reset and are read only below the held count
`default_nettype none
module lru_segment_buffer_tracker
  import lsbt_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // command channel
  input  wire logic                     start,
  output logic                          busy,
  input  wire in_word_t                 in_word,
  // result channel
  output logic                          out_valid,
  output out_word_t                     out_word,
  // configuration port
  input  wire logic                     cfg_psel,
  input  wire logic                     cfg_penable,
  input  wire logic                     cfg_pwrite,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_paddr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_pwdata,
  output logic [CFG_DATA_BITS-1:0]      cfg_prdata,
  output logic                          cfg_pready
);

  localparam int CW   = $clog2(ENTRIES + 1);
  localparam int IW   = $clog2(ENTRIES);
  localparam int CAPW = (CW > CAP_BITS) ? CW : CAP_BITS;

  logic [CAP_BITS-1:0] capacity_r;
  logic [CW-1:0]       held_r;
  logic [CW-1:0]       held_nxt;
  logic                out_valid_r;
  out_word_t           out_word_r;
  out_word_t           out_word_nxt;

  key_t                in_key;
  key_t                cell_key [ENTRIES];
  key_t                nbr_key  [ENTRIES];
  cell_ctl_t           cell_ctl [ENTRIES];
  logic [ENTRIES-1:0]  raw_hit;
  logic [ENTRIES-1:0]  match;
  logic [IW-1:0]       hit_pos;
  logic                any_hit;

  logic [CAPW-1:0]     eff_cap;
  logic                accept;
  logic                is_wr;
  logic                is_rd;
  logic                is_q;
  logic                evict;
  logic                dup;
  logic                remove;
  logic [IW-1:0]       rm_pos;
  logic                append;
  logic [CW-1:0]       new_cnt;

  assign busy       = 1'b0;
  assign accept     = start && !busy;
  assign cfg_pready = 1'b1;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r <= CAP_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr == ADDR_CAPACITY) begin
      capacity_r <= cfg_pwdata[CAP_BITS-1:0];
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr == ADDR_CAPACITY) begin
      cfg_prdata = CFG_DATA_BITS'(capacity_r);
    end
  end

  // effective capacity, clamped to 1..ENTRIES
  always_comb begin
    eff_cap = CAPW'(capacity_r);
    if (capacity_r == '0) begin
      eff_cap = CAPW'(1);
    end else if (CAPW'(capacity_r) > CAPW'(ENTRIES)) begin
      eff_cap = CAPW'(ENTRIES);
    end
  end

  assign in_key.file_id = in_word.file_id;
  assign in_key.seg_id  = in_word.seg_id;

  // the cell chain
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    if (i == ENTRIES - 1) begin : g_last
      assign nbr_key[i] = cell_key[i];
    end else begin : g_mid
      assign nbr_key[i] = cell_key[i+1];
    end

    lsbt_cell u_cell (
      .clk     (clk),
      .nbr_key (nbr_key[i]),
      .in_key  (in_key),
      .ctl     (cell_ctl[i]),
      .key     (cell_key[i]),
      .hit     (raw_hit[i])
    );

    assign match[i] = raw_hit[i] && (CW'(i) < held_r);

    // shift cells from the removed place up; load the new newest place
    assign cell_ctl[i].shift = remove && (IW'(i) >= rm_pos) && (CW'(i + 1) < held_r);
    assign cell_ctl[i].load  = append && (CW'(i) == new_cnt);
  end

  // keys are unique, so at most one cell matches
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        hit_pos = hit_pos | IW'(i);
      end
    end
  end
  assign any_hit = |match;

  // command decode and list update plan
  always_comb begin
    is_wr   = accept && (in_word.cmd == CMD_WRITE);
    is_rd   = accept && (in_word.cmd == CMD_READ);
    is_q    = accept && (in_word.cmd == CMD_QUERY);
    evict   = is_wr && (CAPW'(held_r) >= eff_cap) && (held_r != '0);
    // the evicted oldest key no longer counts as present
    dup     = is_wr && |(match & ~ENTRIES'(evict));
    remove  = evict || (is_rd && any_hit);
    rm_pos  = evict ? '0 : hit_pos;
    append  = (is_wr && !dup) || (is_rd && any_hit);
    new_cnt = held_r - CW'(remove);
    held_nxt = new_cnt + CW'(append);
  end

  // result word
  always_comb begin
    out_word_nxt = '0;
    if (is_wr && dup) begin
      out_word_nxt.status = ST_DUP;
    end else if (is_rd && !any_hit) begin
      out_word_nxt.status = ST_MISS;
    end
    out_word_nxt.present = is_q && any_hit;
    out_word_nxt.evicted = evict;
    if (evict) begin
      out_word_nxt.evicted_file_id = cell_key[0].file_id;
      out_word_nxt.evicted_seg_id  = cell_key[0].seg_id;
    end
    out_word_nxt.added = is_wr && !dup;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
      if (accept) begin
        held_r <= held_nxt;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
`default_nettype wire

/* dv/lru_segment_buffer_tracker_tb.sv */
// self-checking testbench for lru_segment_buffer_tracker: directed and random command words
// depends on lsbt_pkg and the tracker rtl; keeps its own model of the key list to predict results
`timescale 1ns / 1ps
module lru_segment_buffer_tracker_tb
  import lsbt_pkg::*;
();

  localparam logic [1:0] CMD_UNUSED  = 2'd3;
  localparam int         POOL_KEYS   = 24;
  localparam int         CYCLE_LIMIT = 400000;

  // key list model and the queue of results still owed by the block
  class key_list_scoreboard;
    key_t                held_keys[$];
    logic [CAP_BITS-1:0] capacity;
    out_word_t           expected_results[$];
    int                  mismatches;

    function new();
      capacity   = CAP_RESET;
      mismatches = 0;
    endfunction

    function void set_capacity(logic [CFG_DATA_BITS-1:0] data);
      capacity = data[CAP_BITS-1:0];
    endfunction

    // zero acts as one, anything past the cell count acts as the cell count
    function int usable_slots();
      if (capacity == 0) return 1;
      if (capacity > ENTRIES_DEF) return ENTRIES_DEF;
      return int'(capacity);
    endfunction

    function int find_key(key_t k);
      foreach (held_keys[i]) if (held_keys[i] == k) return i;
      return -1;
    endfunction

    function out_word_t predict_result(in_word_t w);
      out_word_t r;
      key_t      k;
      int        pos;
      r         = '0;
      k.file_id = w.file_id;
      k.seg_id  = w.seg_id;
      case (w.cmd)
        CMD_WRITE: begin
          // eviction comes first, even when the key turns out to be a duplicate
          if (held_keys.size() >= usable_slots() && held_keys.size() > 0) begin
            key_t old;
            old = held_keys[0];
            held_keys.delete(0);
            r.evicted         = 1'b1;
            r.evicted_file_id = old.file_id;
            r.evicted_seg_id  = old.seg_id;
          end
          if (find_key(k) >= 0) begin
            r.status = ST_DUP;
          end else begin
            if (held_keys.size() < ENTRIES_DEF) held_keys.insert(held_keys.size(), k);
            r.added = 1'b1;
          end
        end
        CMD_READ: begin
          // a hit moves the key to the newest end
          pos = find_key(k);
          if (pos >= 0) begin
            held_keys.delete(pos);
            held_keys.insert(held_keys.size(), k);
          end else begin
            r.status = ST_MISS;
          end
        end
        CMD_QUERY: r.present = (find_key(k) >= 0);
        default: ;
      endcase
      return r;
    endfunction

    function void note_word(in_word_t w);
      expected_results.insert(expected_results.size(), predict_result(w));
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_result(out_word_t got);
      out_word_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = expected_results[0];
      expected_results.delete(0);
      compare_field("status", 64'(want.status), 64'(got.status));
      compare_field("present", 64'(want.present), 64'(got.present));
      compare_field("evicted", 64'(want.evicted), 64'(got.evicted));
      compare_field("evicted_file_id", 64'(want.evicted_file_id), 64'(got.evicted_file_id));
      compare_field("evicted_seg_id", 64'(want.evicted_seg_id), 64'(got.evicted_seg_id));
      compare_field("added", 64'(want.added), 64'(got.added));
    endfunction

    function int outstanding();
      return expected_results.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  in_word_t                 in_word;
  logic                     out_valid;
  out_word_t                out_word;
  logic                     cfg_psel;
  logic                     cfg_penable;
  logic                     cfg_pwrite;
  logic [CFG_ADDR_BITS-1:0] cfg_paddr;
  logic [CFG_DATA_BITS-1:0] cfg_pwdata;
  logic [CFG_DATA_BITS-1:0] cfg_prdata;
  logic                     cfg_pready;

  key_list_scoreboard sb = new();
  key_t               key_pool[POOL_KEYS];
  int                 pool_span;
  bit                 no_idle;
  int                 cycle_count = 0;

  lru_segment_buffer_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_valid  (out_valid),
    .out_word   (out_word),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always #6 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // result monitor, sampled on the edge that ends the strobe cycle
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid !== 1'b0) sb.check_result(out_word);
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_word_t make_word(logic [1:0] cmd, key_t k);
    in_word_t w;
    w.cmd     = cmd;
    w.file_id = k.file_id;
    w.seg_id  = k.seg_id;
    return w;
  endfunction

  // present one word and hold it until the block takes it
  task automatic send_word(input in_word_t w);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_word(w);
  endtask

  // capacity write, only once every owed result has come back
  task automatic write_capacity(input logic [4:0] cap);
    logic [CFG_DATA_BITS-1:0] data;
    data      = $urandom();
    data[4:0] = cap;
    start <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_CAPACITY;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    sb.set_capacity(data);
  endtask

  function automatic key_t pick_key();
    key_t k;
    if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, pool_span - 1)];
    k.file_id = FILE_ID_BITS'($urandom());
    k.seg_id  = SEG_ID_BITS'($urandom());
    return k;
  endfunction

  function automatic logic [1:0] pick_cmd();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_WRITE;
    if (r < 75) return CMD_READ;
    if (r < 95) return CMD_QUERY;
    return CMD_UNUSED;
  endfunction

  initial begin
    logic [4:0] phase_caps[9];
    key_t       k_zero, k_max, k_a;
    int         drain_wait;

    rst_n       <= 1'b0;
    start       <= 1'b0;
    in_word     <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    no_idle     = 1'b0;
    pool_span   = POOL_KEYS;

    // key pool with the extremes in front
    foreach (key_pool[i]) begin
      key_pool[i].file_id = FILE_ID_BITS'($urandom());
      key_pool[i].seg_id  = SEG_ID_BITS'($urandom());
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    k_zero = key_pool[0];
    k_max  = key_pool[1];
    k_a    = key_pool[2];

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every command, duplicate, hit and miss
    send_word(make_word(CMD_WRITE, k_max));
    send_word(make_word(CMD_WRITE, k_zero));
    send_word(make_word(CMD_WRITE, k_zero));
    send_word(make_word(CMD_QUERY, k_max));
    send_word(make_word(CMD_QUERY, k_a));
    send_word(make_word(CMD_READ, k_max));
    send_word(make_word(CMD_READ, k_a));
    send_word(make_word(CMD_UNUSED, k_max));
    for (int i = 3; i < 9; i++) send_word(make_word(CMD_WRITE, key_pool[i]));

    // capacity dropped below the held count: one eviction per write
    write_capacity(5'd2);
    send_word(make_word(CMD_WRITE, k_max));
    send_word(make_word(CMD_WRITE, key_pool[9]));
    send_word(make_word(CMD_QUERY, key_pool[3]));

    // single slot: each write evicts the oldest key, and the repeated write is a duplicate
    write_capacity(5'd1);
    send_word(make_word(CMD_WRITE, k_a));
    send_word(make_word(CMD_WRITE, k_a));
    send_word(make_word(CMD_READ, k_a));

    // zero capacity behaves as one slot
    write_capacity(5'd0);
    send_word(make_word(CMD_WRITE, k_a));
    send_word(make_word(CMD_WRITE, k_zero));

    // random phases over a spread of capacities, extremes included
    phase_caps = '{5'd31, 5'd1, 5'd2, 5'd16, 5'd0, 5'd4, 5'd17, 5'd8, 5'd16};
    phase_caps[7] = 5'($urandom_range(0, 31));
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      pool_span = $urandom_range(2, POOL_KEYS);
      for (int n = 0; n < 205; n++) begin
        if (n % 50 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_word(make_word(pick_cmd(), pick_key()));
      end
    end

    // drain and wrap up
    start <= 1'b0;
    drain_wait = 0;
    while (sb.outstanding() != 0 && drain_wait < 1000) begin
      @(posedge clk);
      drain_wait++;
    end
    repeat (4) @(posedge clk);
    if (sb.outstanding() != 0) begin
      sb.mismatches++;
      $display("%0t: %0d results never arrived", $time, sb.outstanding());
    end
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
